>>> sv/tcw_pkg.sv
package tcw_pkg;

  localparam int DEF_MAX_COLUMNS = 80;
  localparam int DEF_MAX_ROWS    = 25;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] RETURN_CODE  = 8'h0D;
  localparam logic [7:0] DEFAULT_ATTR = 8'h0F;
  localparam logic [6:0] RST_COLUMNS  = 7'd80;
  localparam logic [4:0] RST_ROWS     = 5'd25;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_MOVE  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_ENDL  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MS_CUR_COL = 2'd0,
    MS_CUR_ROW = 2'd1,
    MS_IN_COL  = 2'd2,
    MS_IN_ROW  = 2'd3
  } mod_sel_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT_WR,
    OP_LATCH,
    OP_MOD_LD,
    OP_MOD_WB,
    OP_WRITE_CH,
    OP_NL_DOWN,
    OP_NL_BOTTOM,
    OP_SCR_RD,
    OP_SCR_WR,
    OP_BOT_START,
    OP_BOT_RD,
    OP_BOT_WR,
    OP_CLR_START,
    OP_CLR_WR,
    OP_SET_CUR,
    OP_RD_CELL,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_MCOL,
    S_MCOL_W,
    S_MROW,
    S_MROW_W,
    S_DISPATCH,
    S_WRAP,
    S_NL,
    S_SCR_RD,
    S_SCR_WR,
    S_BOT_RD,
    S_BOT_WR,
    S_CLR,
    S_MICOL,
    S_MICOL_W,
    S_MIROW,
    S_MIROW_W,
    S_POST,
    S_RD,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t      op;
    mod_sel_t mod_sel;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       ch_nl;
    logic       ch_cr;
    logic       cur_col_ge;
    logic       cur_row_ge;
    logic       in_col_ge;
    logic       in_row_ge;
    logic       col_nz;
    logic       last_row;
    logic       mod_done;
    logic       scroll_done;
    logic       area_last;
    logic       cell_last;
  } status_t;

endpackage

>>> sv/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tcw_ctrl.sv
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  tcw_pkg::status_t st,
  output tcw_pkg::ctrl_t   ctrl,
  output logic             busy
);
  import tcw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctrl.op      = OP_NONE;
    ctrl.mod_sel = MS_CUR_COL;
    busy         = (state_r != S_IDLE);
    case (state_r)
      S_INIT: begin
        ctrl.op = OP_INIT_WR;
        if (st.cell_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctrl.op   = OP_LATCH;
          state_nxt = S_MCOL;
        end
      end
      S_MCOL: begin
        if (st.cur_col_ge) begin
          ctrl.op   = OP_MOD_LD;
          state_nxt = S_MCOL_W;
        end else begin
          state_nxt = S_MROW;
        end
      end
      S_MCOL_W: begin
        if (st.mod_done) begin
          ctrl.op   = OP_MOD_WB;
          state_nxt = S_MROW;
        end
      end
      S_MROW: begin
        ctrl.mod_sel = MS_CUR_ROW;
        if (st.cur_row_ge) begin
          ctrl.op   = OP_MOD_LD;
          state_nxt = S_MROW_W;
        end else begin
          state_nxt = S_DISPATCH;
        end
      end
      S_MROW_W: begin
        ctrl.mod_sel = MS_CUR_ROW;
        if (st.mod_done) begin
          ctrl.op   = OP_MOD_WB;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.cmd)
          CMD_WRITE: begin
            if (st.ch_nl) begin
              state_nxt = S_NL;
            end else if (st.ch_cr) begin
              state_nxt = S_DONE;
            end else begin
              ctrl.op   = OP_WRITE_CH;
              state_nxt = S_WRAP;
            end
          end
          CMD_MOVE, CMD_READ: state_nxt = S_MICOL;
          CMD_CLEAR: begin
            ctrl.op   = OP_CLR_START;
            state_nxt = S_CLR;
          end
          CMD_ENDL: state_nxt = st.col_nz ? S_NL : S_DONE;
          default: state_nxt = S_DONE;
        endcase
      end
      S_WRAP: state_nxt = st.cur_col_ge ? S_NL : S_DONE;
      S_NL: begin
        if (st.last_row) begin
          ctrl.op   = OP_NL_BOTTOM;
          state_nxt = S_SCR_RD;
        end else begin
          ctrl.op   = OP_NL_DOWN;
          state_nxt = S_DONE;
        end
      end
      S_SCR_RD: begin
        if (st.scroll_done) begin
          ctrl.op   = OP_BOT_START;
          state_nxt = S_BOT_RD;
        end else begin
          ctrl.op   = OP_SCR_RD;
          state_nxt = S_SCR_WR;
        end
      end
      S_SCR_WR: begin
        ctrl.op   = OP_SCR_WR;
        state_nxt = S_SCR_RD;
      end
      S_BOT_RD: begin
        ctrl.op   = OP_BOT_RD;
        state_nxt = S_BOT_WR;
      end
      S_BOT_WR: begin
        ctrl.op   = OP_BOT_WR;
        state_nxt = st.area_last ? S_DONE : S_BOT_RD;
      end
      S_CLR: begin
        ctrl.op = OP_CLR_WR;
        if (st.area_last) state_nxt = S_DONE;
      end
      S_MICOL: begin
        ctrl.mod_sel = MS_IN_COL;
        if (st.in_col_ge) begin
          ctrl.op   = OP_MOD_LD;
          state_nxt = S_MICOL_W;
        end else begin
          state_nxt = S_MIROW;
        end
      end
      S_MICOL_W: begin
        ctrl.mod_sel = MS_IN_COL;
        if (st.mod_done) begin
          ctrl.op   = OP_MOD_WB;
          state_nxt = S_MIROW;
        end
      end
      S_MIROW: begin
        ctrl.mod_sel = MS_IN_ROW;
        if (st.in_row_ge) begin
          ctrl.op   = OP_MOD_LD;
          state_nxt = S_MIROW_W;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_MIROW_W: begin
        ctrl.mod_sel = MS_IN_ROW;
        if (st.mod_done) begin
          ctrl.op   = OP_MOD_WB;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (st.cmd == CMD_READ) begin
          state_nxt = S_RD;
        end else begin
          ctrl.op   = OP_SET_CUR;
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        ctrl.op   = OP_RD_CELL;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ctrl.op   = OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> sv/tcw_dp.sv
module tcw_dp #(
  parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcw_pkg::ctrl_t   ctrl,
  output tcw_pkg::status_t st,
  input  logic [2:0]       in_command,
  input  logic [7:0]       in_character,
  input  logic [7:0]       in_column,
  input  logic [7:0]       in_row,
  input  logic [7:0]       in_attribute,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  output logic             out_valid,
  output logic [6:0]       out_cursor_column,
  output logic [4:0]       out_cursor_row,
  output logic [7:0]       out_read_character,
  output logic [7:0]       out_read_attribute
);
  import tcw_pkg::*;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = (AW > 13) ? AW : 13;

  logic [6:0]    cols_r;
  logic [4:0]    rows_r;
  logic [6:0]    cur_col_r;
  logic [4:0]    cur_row_r;
  logic [7:0]    attr_r;
  logic [2:0]    cmd_r;
  logic [7:0]    ch_r, icol_r, irow_r, iattr_r;
  logic [AW-1:0] wa_r;
  logic [7:0]    mod_a_r, mod_rem_r;
  logic [6:0]    mod_div_r;
  logic [3:0]    mod_cnt_r;
  logic          out_valid_r;
  logic [6:0]    out_col_r;
  logic [4:0]    out_row_r;
  logic [7:0]    out_ch_r, out_attr_r;

  logic [6:0]    c;
  logic [4:0]    r;
  logic [CW-1:0] rc, lim_scr, cur_idx, in_idx, wa_x;
  logic [7:0]    mod_t;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  always_comb begin
    if (cols_r == 7'd0) c = 7'd1;
    else if ({1'b0, cols_r} > 8'(MAX_COLUMNS)) c = 7'(MAX_COLUMNS);
    else c = cols_r;
    if (rows_r == 5'd0) r = 5'd1;
    else if ({3'b0, rows_r} > 8'(MAX_ROWS)) r = 5'(MAX_ROWS);
    else r = rows_r;
  end

  assign rc      = CW'(r) * CW'(c);
  assign lim_scr = CW'(r - 5'd1) * CW'(c);
  assign cur_idx = CW'(cur_row_r) * CW'(c) + CW'(cur_col_r);
  assign in_idx  = CW'(irow_r[4:0]) * CW'(c) + CW'(icol_r[6:0]);
  assign wa_x    = CW'(wa_r);
  assign mod_t   = {mod_rem_r[6:0], mod_a_r[7]};

  always_comb begin
    st.cmd         = cmd_r;
    st.ch_nl       = (ch_r == NEWLINE_CODE);
    st.ch_cr       = (ch_r == RETURN_CODE);
    st.cur_col_ge  = (cur_col_r >= c);
    st.cur_row_ge  = (cur_row_r >= r);
    st.in_col_ge   = (icol_r >= {1'b0, c});
    st.in_row_ge   = (irow_r >= {3'b0, r});
    st.col_nz      = (cur_col_r != 7'd0);
    st.last_row    = ({1'b0, cur_row_r} + 6'd1 >= {1'b0, r});
    st.mod_done    = (mod_cnt_r == 4'd8);
    st.scroll_done = (wa_x >= lim_scr);
    st.area_last   = (wa_x == rc - CW'(1));
    st.cell_last   = (wa_x == CW'(CELLS - 1));
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = wa_r;
    raddr = wa_r;
    wdata = {DEFAULT_ATTR, SPACE_CODE};
    case (ctrl.op)
      OP_INIT_WR: we = 1'b1;
      OP_WRITE_CH: begin
        we    = 1'b1;
        waddr = AW'(cur_idx);
        wdata = {attr_r, ch_r};
      end
      OP_SCR_RD: begin
        re    = 1'b1;
        raddr = AW'(wa_x + CW'(c));
      end
      OP_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_BOT_RD: re = 1'b1;
      OP_BOT_WR: begin
        we    = 1'b1;
        wdata = {rdata[15:8], SPACE_CODE};
      end
      OP_CLR_WR: begin
        we    = 1'b1;
        wdata = {attr_r, SPACE_CODE};
      end
      OP_RD_CELL: begin
        re    = 1'b1;
        raddr = AW'(in_idx);
      end
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= RST_COLUMNS;
      rows_r      <= RST_ROWS;
      cur_col_r   <= 7'd0;
      cur_row_r   <= 5'd0;
      attr_r      <= DEFAULT_ATTR;
      wa_r        <= '0;
      mod_cnt_r   <= 4'd8;
      mod_rem_r   <= 8'd0;
      mod_div_r   <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctrl.op == OP_EMIT);
      if (cfg_valid) begin
        if (cfg_index == CFG_COLUMNS) cols_r <= cfg_data[6:0];
        else if (cfg_index == CFG_ROWS) rows_r <= cfg_data[4:0];
      end
      if (mod_cnt_r != 4'd8) begin
        mod_cnt_r <= mod_cnt_r + 4'd1;
        mod_a_r   <= {mod_a_r[6:0], 1'b0};
        mod_rem_r <= (mod_t >= {1'b0, mod_div_r}) ? mod_t - {1'b0, mod_div_r} : mod_t;
      end
      case (ctrl.op)
        OP_INIT_WR, OP_SCR_WR, OP_BOT_WR, OP_CLR_WR: wa_r <= wa_r + AW'(1);
        OP_LATCH: begin
          cmd_r   <= in_command;
          ch_r    <= in_character;
          icol_r  <= in_column;
          irow_r  <= in_row;
          iattr_r <= in_attribute;
        end
        OP_MOD_LD: begin
          mod_cnt_r <= 4'd0;
          mod_rem_r <= 8'd0;
          case (ctrl.mod_sel)
            MS_CUR_COL: begin
              mod_a_r   <= {1'b0, cur_col_r};
              mod_div_r <= c;
            end
            MS_CUR_ROW: begin
              mod_a_r   <= {3'b0, cur_row_r};
              mod_div_r <= {2'b0, r};
            end
            MS_IN_COL: begin
              mod_a_r   <= icol_r;
              mod_div_r <= c;
            end
            default: begin
              mod_a_r   <= irow_r;
              mod_div_r <= {2'b0, r};
            end
          endcase
        end
        OP_MOD_WB: begin
          case (ctrl.mod_sel)
            MS_CUR_COL: cur_col_r <= mod_rem_r[6:0];
            MS_CUR_ROW: cur_row_r <= mod_rem_r[4:0];
            MS_IN_COL:  icol_r    <= mod_rem_r;
            default:    irow_r    <= mod_rem_r;
          endcase
        end
        OP_WRITE_CH: cur_col_r <= cur_col_r + 7'd1;
        OP_NL_DOWN: begin
          cur_row_r <= cur_row_r + 5'd1;
          cur_col_r <= 7'd0;
        end
        OP_NL_BOTTOM: begin
          cur_row_r <= r - 5'd1;
          cur_col_r <= 7'd0;
          wa_r      <= '0;
        end
        OP_BOT_START: wa_r <= AW'(lim_scr);
        OP_CLR_START: begin
          attr_r    <= iattr_r;
          cur_col_r <= 7'd0;
          cur_row_r <= 5'd0;
          wa_r      <= '0;
        end
        OP_SET_CUR: begin
          cur_col_r <= icol_r[6:0];
          cur_row_r <= irow_r[4:0];
        end
        OP_EMIT: begin
          out_col_r   <= cur_col_r;
          out_row_r   <= cur_row_r;
          out_ch_r    <= (cmd_r == CMD_READ) ? rdata[7:0] : 8'd0;
          out_attr_r  <= (cmd_r == CMD_READ) ? rdata[15:8] : 8'd0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_column  = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_read_character = out_ch_r;
  assign out_read_attribute = out_attr_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mod_cnt_r == 4'd8) |-> (mod_rem_r < {1'b0, mod_div_r}))
    else $error("remainder not below divisor");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (CW'(waddr) < CW'(CELLS)))
    else $error("screen write out of range");

endmodule

>>> sv/text_console_writer.sv
// Channel   Handshake                Payload
// in        start / busy             in_command, in_character, in_column, in_row, in_attribute
// out       out_valid (strobe)       out_cursor_column, out_cursor_row, out_read_*
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
// One command in flight. Each cursor or operand reduction uses the shared bit-serial
// remainder unit. A scroll moves each row up and blanks the characters of the bottom row;
// clear fills all rows*columns cells with spaces in the new attribute.
// The result strobe is high in the first cycle in which busy is low.
// After reset a fill pass over all MAX_COLUMNS*MAX_ROWS cells holds busy high.
// Results are a one-cycle strobe; the receiver cannot stall. cfg_ready is always high.
module text_console_writer #(
  parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_command,
  input  logic [7:0] in_character,
  input  logic [7:0] in_column,
  input  logic [7:0] in_row,
  input  logic [7:0] in_attribute,
  output logic       out_valid,
  output logic [6:0] out_cursor_column,
  output logic [4:0] out_cursor_row,
  output logic [7:0] out_read_character,
  output logic [7:0] out_read_attribute,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tcw_pkg::*;

  ctrl_t   ctrl;
  status_t st;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .st   (st),
    .ctrl (ctrl),
    .busy (busy)
  );

  tcw_dp #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .st                (st),
    .in_command        (in_command),
    .in_character      (in_character),
    .in_column         (in_column),
    .in_row            (in_row),
    .in_attribute      (in_attribute),
    .cfg_valid         (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_read_character(out_read_character),
    .out_read_attribute(out_read_attribute)
  );

endmodule

>>> test/text_console_writer_test.sv
module text_console_writer_test;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS_MAX   = DEF_MAX_COLUMNS;
  localparam int ROWS_MAX   = DEF_MAX_ROWS;
  localparam int CELLS      = COLS_MAX * ROWS_MAX;
  localparam int CYCLE_CAP  = 10_000_000;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] ch;
    logic [7:0] attr;
  } cursor_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_command = '0;
  logic [7:0] in_character = '0;
  logic [7:0] in_column = '0;
  logic [7:0] in_row = '0;
  logic [7:0] in_attribute = '0;
  logic       out_valid;
  logic [6:0] out_cursor_column;
  logic [4:0] out_cursor_row;
  logic [7:0] out_read_character;
  logic [7:0] out_read_attribute;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  text_console_writer DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // screen model
  logic [15:0]    screen [CELLS];
  int unsigned    cur_col, cur_row;
  logic [7:0]     cur_attr;
  logic [6:0]     columns_reg;
  logic [4:0]     rows_reg;
  cursor_result_t pending_results[$];
  int unsigned    errors = 0;
  int unsigned    cycles = 0;
  bit             gaps_on = 1'b1;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int unsigned live_cols();
    if (columns_reg == 0) return 1;
    if (columns_reg > COLS_MAX) return COLS_MAX;
    return columns_reg;
  endfunction

  function automatic int unsigned live_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > ROWS_MAX) return ROWS_MAX;
    return rows_reg;
  endfunction

  function automatic int unsigned cell_at(int unsigned c, int unsigned r);
    int unsigned k;
    k = r * live_cols() + c;
    return (k < CELLS) ? k : 0;
  endfunction

  task automatic line_feed();
    int unsigned nc, nr;
    nc = live_cols();
    nr = live_rows();
    if (cur_row + 1 >= nr) begin
      for (int unsigned k = 0; k < (nr - 1) * nc; k++) screen[k] = screen[k + nc];
      for (int unsigned k = 0; k < nc; k++)
        screen[(nr - 1) * nc + k][7:0] = SPACE_CODE;
      cur_row = nr - 1;
    end else begin
      cur_row++;
    end
    cur_col = 0;
  endtask

  task automatic console_model(input logic [2:0] cmd, input logic [7:0] ch,
                               input logic [7:0] col, input logic [7:0] row,
                               input logic [7:0] attr);
    int unsigned    nc, nr, k;
    cursor_result_t res;
    nc = live_cols();
    nr = live_rows();
    res.ch = '0;
    res.attr = '0;
    cur_col %= nc;
    cur_row %= nr;
    case (cmd)
      CMD_WRITE: begin
        if (ch == NEWLINE_CODE) begin
          line_feed();
        end else if (ch != RETURN_CODE) begin
          screen[cell_at(cur_col, cur_row)] = {cur_attr, ch};
          cur_col++;
          if (cur_col >= nc) line_feed();
        end
      end
      CMD_MOVE: begin
        cur_col = col % nc;
        cur_row = row % nr;
      end
      CMD_CLEAR: begin
        cur_attr = attr;
        cur_col = 0;
        cur_row = 0;
        for (k = 0; k < nc * nr; k++) screen[k] = {attr, SPACE_CODE};
      end
      CMD_ENDL: begin
        if (cur_col > 0) line_feed();
      end
      CMD_READ: begin
        k = cell_at(col % nc, row % nr);
        res.ch = screen[k][7:0];
        res.attr = screen[k][15:8];
      end
      default: ;
    endcase
    res.col = cur_col[6:0];
    res.row = cur_row[4:0];
    pending_results.push_back(res);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    cursor_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("result with no transaction pending");
      end else begin
        want = pending_results.pop_front();
        if (out_cursor_column !== want.col)
          report($sformatf("cursor_column %0d, want %0d", out_cursor_column, want.col));
        if (out_cursor_row !== want.row)
          report($sformatf("cursor_row %0d, want %0d", out_cursor_row, want.row));
        if (out_read_character !== want.ch)
          report($sformatf("read_character %h, want %h", out_read_character, want.ch));
        if (out_read_attribute !== want.attr)
          report($sformatf("read_attribute %h, want %h", out_read_attribute, want.attr));
      end
    end
  end

  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                          input logic [7:0] col, input logic [7:0] row,
                          input logic [7:0] attr);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_character <= ch;
    in_column <= col;
    in_row <= row;
    in_attribute <= attr;
    while (busy) @(negedge clk);
    @(posedge clk);
    console_model(cmd, ch, col, row, attr);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_COLUMNS) columns_reg = data[6:0];
    else if (idx == CFG_ROWS) rows_reg = data[4:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    int unsigned pick;
    logic [7:0]  ch;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? NEWLINE_CODE :
           ($urandom_range(0, 19) == 0) ? RETURN_CODE : 8'($urandom);
      if (pick < 50)
        send_cmd(CMD_WRITE, ch, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 63)
        send_cmd(CMD_MOVE, ch, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 66)
        send_cmd(CMD_CLEAR, ch, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 76)
        send_cmd(CMD_ENDL, ch, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 96)
        send_cmd(CMD_READ, ch, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_cmd(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), ch,
                 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_reset_contents();
    send_cmd(CMD_READ, 8'h00, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_READ, 8'hFF, 8'd255, 8'd255, 8'hFF);
    send_cmd(CMD_READ, 8'h00, 8'd79, 8'd24, 8'h00);
  endtask

  task automatic test_commands();
    send_cmd(CMD_WRITE, 8'h00, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_WRITE, 8'hFF, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_WRITE, RETURN_CODE, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_ENDL, 8'h00, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_ENDL, 8'h00, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_WRITE, NEWLINE_CODE, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_READ, 8'h00, 8'd1, 8'd0, 8'h00);
    send_cmd(CMD_MOVE, 8'h00, 8'd255, 8'd255, 8'h00);
    send_cmd(CMD_WRITE, 8'h41, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_CLEAR, 8'h00, 8'd0, 8'd0, 8'hFF);
    send_cmd(CMD_READ, 8'h00, 8'd3, 8'd3, 8'h00);
    send_cmd(CMD_CLEAR, 8'h00, 8'd0, 8'd0, 8'h00);
    for (logic [3:0] c = {1'b0, CMD_SPARE_FIRST}; c <= {1'b0, CMD_SPARE_LAST}; c++)
      send_cmd(c[2:0], 8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // wrap at last column and scroll at last row on a tiny screen
  task automatic test_wrap_scroll();
    cfg_write(CFG_COLUMNS, 8'd3);
    cfg_write(CFG_ROWS, 8'd2);
    for (int i = 0; i < 8; i++) send_cmd(CMD_WRITE, 8'h61 + 8'(i), 8'd0, 8'd0, 8'h00);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++)
        send_cmd(CMD_READ, 8'h00, 8'(c), 8'(r), 8'h00);
    send_cmd(CMD_WRITE, NEWLINE_CODE, 8'd0, 8'd0, 8'h00);
  endtask

  task automatic test_config_extremes();
    cfg_write(CFG_COLUMNS, 8'd0);
    cfg_write(CFG_ROWS, 8'd0);
    send_random(15);
    cfg_write(CFG_COLUMNS, 8'hFF);
    cfg_write(CFG_ROWS, 8'hFF);
    send_cmd(CMD_MOVE, 8'h00, 8'd79, 8'd24, 8'h00);
    send_cmd(CMD_WRITE, 8'h5A, 8'd0, 8'd0, 8'h00);
    cfg_write(CFG_SPARE_A, 8'd5);
    cfg_write(CFG_SPARE_B, 8'd5);
    // shrink with the cursor outside the new area
    cfg_write(CFG_COLUMNS, 8'd7);
    cfg_write(CFG_ROWS, 8'd4);
    send_cmd(CMD_ENDL, 8'h00, 8'd0, 8'd0, 8'h00);
    send_cmd(CMD_READ, 8'h00, 8'd200, 8'd200, 8'h00);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 12; p++) begin
      if (p == 11) gaps_on = 1'b0;
      if (p == 3) begin
        cfg_write(CFG_COLUMNS, 8'd80);
        cfg_write(CFG_ROWS, 8'd25);
        send_random(60);
      end else if (p == 6) begin
        cfg_write(CFG_COLUMNS, 8'($urandom));
        cfg_write(CFG_ROWS, 8'($urandom));
        send_random(60);
      end else begin
        cfg_write(CFG_COLUMNS, 8'($urandom_range(1, 12)));
        cfg_write(CFG_ROWS, 8'($urandom_range(1, 6)));
        send_random(200);
      end
    end
  endtask

  initial begin
    for (int k = 0; k < CELLS; k++) screen[k] = {DEFAULT_ATTR, SPACE_CODE};
    cur_col = 0;
    cur_row = 0;
    cur_attr = DEFAULT_ATTR;
    columns_reg = RST_COLUMNS;
    rows_reg = RST_ROWS;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_contents();
    test_commands();
    test_wrap_scroll();
    test_config_extremes();
    test_random_phases();
    settle();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
